### rtl/tsoa_pkg.sv
`default_nettype none
package tsoa_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    // slot index width
    localparam int IW     = $clog2(DEPTH);
    // stack pointers span -1 .. DEPTH, so two extra bits with sign
    localparam int PW     = IW + 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PW-1:0]     t_ptr;
    typedef logic        [IW-1:0]     t_addr;

    localparam t_ptr PTR_DEPTH     = t_ptr'(DEPTH);
    localparam t_ptr PTR_NEG_ONE   = -t_ptr'(1);
    localparam t_ptr PTR_MID_TOP   = t_ptr'(DEPTH / 2);
    localparam t_ptr PTR_MID_BOT   = t_ptr'(DEPTH / 2 + 1);

    localparam logic       OP_PUSH  = 1'b0;
    localparam logic [1:0] SEL_LOW  = 2'd0;
    localparam logic [1:0] SEL_HIGH = 2'd1;

endpackage
`default_nettype wire

### rtl/three_stacks_one_array.sv
// three_stacks_one_array: three stacks sharing one store of DEPTH words.
// input channel: i_in_valid / o_in_stall carry one word of op, stack_select
// and value; output channel: o_out_valid / i_out_stall carry one result word
// with success, popped_value and the full and empty flags.
// one item is worked at a time; o_in_stall is high from acceptance until the
// result has been written into the output register.
// a plain push or pop goes through check, store access and finish before
// the result is valid; the next word is taken once the sequencer is back
// in idle. a refused push or a pop on an empty stack skips the store access.
// a push that has to shift the middle stack first copies its words one at a
// time through the single store port, each word read, then written.
// the output register lets the next item be accepted while a result waits;
// a finished result waits in its own step while the receiver stalls and the
// output register is still full.
// reset puts all three stacks at empty (low at -1, high at DEPTH, middle at
// DEPTH/2) and clears valid; the store contents are not cleared and no
// clearing pass is needed.
`default_nettype none
module three_stacks_one_array (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [1:0]            i_stack_select,
    input  wire tsoa_pkg::t_word       i_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_success,
    output tsoa_pkg::t_word            o_popped_value,
    output logic                       o_all_full,
    output logic                       o_low_empty,
    output logic                       o_high_empty,
    output logic                       o_middle_empty
);
    import tsoa_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_MOVE_RD = 3'd2;
    localparam logic [2:0] S_MOVE_WR = 3'd3;
    localparam logic [2:0] S_PUSH    = 3'd4;
    localparam logic [2:0] S_POP_RD  = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    t_word mem [DEPTH];

    logic [2:0] r_state, n_state;
    logic       r_op, n_op;
    logic [1:0] r_sel, n_sel;
    t_word      r_value, n_value;
    t_ptr       r_low_top, n_low_top;
    t_ptr       r_high_top, n_high_top;
    t_ptr       r_mid_top, n_mid_top;
    t_ptr       r_mid_bot, n_mid_bot;
    t_ptr       r_idx, n_idx;
    t_ptr       r_dist, n_dist;
    logic       r_ok, n_ok;
    t_word      r_rd_data;
    logic       r_out_valid, n_out_valid;
    logic       r_o_success;
    t_word      r_o_popped;
    logic       r_o_full, r_o_low_e, r_o_high_e, r_o_mid_e;
    logic       load_out;

    logic       rd_en, wr_en;
    t_addr      rd_addr, wr_addr;
    t_word      wr_data;

    logic       is_full, low_meets_mid, mid_meets_high, mid_nonempty, move_last;
    t_ptr       gap_up, gap_dn, dist_up, dist_dn, wr_ptr;

    assign is_full        = low_meets_mid && mid_meets_high;
    assign low_meets_mid  = (r_low_top + t_ptr'(1)) == r_mid_bot;
    assign mid_meets_high = (r_mid_top + t_ptr'(1)) == r_high_top;
    assign mid_nonempty   = r_mid_top >= r_mid_bot;
    assign gap_up         = r_high_top - r_mid_top - t_ptr'(1);
    assign gap_dn         = r_mid_bot - r_low_top - t_ptr'(1);
    // gaps are never negative here, so the arithmetic shift halves them
    assign dist_up        = (gap_up >>> 1) + t_ptr'(1);
    assign dist_dn        = (gap_dn >>> 1) + t_ptr'(1);
    assign wr_ptr         = r_idx + r_dist;
    // up moves copy top down, down moves copy bottom up
    assign move_last      = r_dist[PW-1] ? (r_idx == r_mid_top) : (r_idx == r_mid_bot);

    assign o_in_stall     = r_state != S_IDLE;
    assign load_out       = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sel       = r_sel;
        n_value     = r_value;
        n_low_top   = r_low_top;
        n_high_top  = r_high_top;
        n_mid_top   = r_mid_top;
        n_mid_bot   = r_mid_bot;
        n_idx       = r_idx;
        n_dist      = r_dist;
        n_ok        = r_ok;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = wr_ptr[IW-1:0];
        wr_data     = r_rd_data;
        n_out_valid = r_out_valid && i_out_stall;
        if (load_out) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_sel   = i_stack_select;
                    n_value = i_value;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ok = 1'b0;
                if (r_op == OP_PUSH) begin
                    if (is_full) begin
                        n_state = S_FINISH;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = S_PUSH;
                        if (r_sel == SEL_LOW && low_meets_mid) begin
                            n_dist = dist_up;
                            n_idx  = r_mid_top;
                            if (mid_nonempty) begin
                                n_state = S_MOVE_RD;
                            end else begin
                                n_mid_top = r_mid_top + dist_up;
                                n_mid_bot = r_mid_bot + dist_up;
                            end
                        end else if (r_sel != SEL_LOW && mid_meets_high) begin
                            n_dist = -dist_dn;
                            n_idx  = r_mid_bot;
                            if (mid_nonempty) begin
                                n_state = S_MOVE_RD;
                            end else begin
                                n_mid_top = r_mid_top - dist_dn;
                                n_mid_bot = r_mid_bot - dist_dn;
                            end
                        end
                    end
                end else begin
                    n_state = S_FINISH;
                    if (r_sel == SEL_LOW) begin
                        if (r_low_top >= t_ptr'(0)) begin
                            n_ok      = 1'b1;
                            rd_en     = 1'b1;
                            rd_addr   = r_low_top[IW-1:0];
                            n_low_top = r_low_top - t_ptr'(1);
                            n_state   = S_POP_RD;
                        end
                    end else if (r_sel == SEL_HIGH) begin
                        if (r_high_top < PTR_DEPTH) begin
                            n_ok       = 1'b1;
                            rd_en      = 1'b1;
                            rd_addr    = r_high_top[IW-1:0];
                            n_high_top = r_high_top + t_ptr'(1);
                            n_state    = S_POP_RD;
                        end
                    end else begin
                        if (mid_nonempty) begin
                            n_ok      = 1'b1;
                            rd_en     = 1'b1;
                            rd_addr   = r_mid_top[IW-1:0];
                            n_mid_top = r_mid_top - t_ptr'(1);
                            n_state   = S_POP_RD;
                        end
                    end
                end
            end
            S_MOVE_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[IW-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                wr_en   = 1'b1;
                wr_addr = wr_ptr[IW-1:0];
                wr_data = r_rd_data;
                if (move_last) begin
                    n_mid_top = r_mid_top + r_dist;
                    n_mid_bot = r_mid_bot + r_dist;
                    n_state   = S_PUSH;
                end else begin
                    n_idx   = r_dist[PW-1] ? (r_idx + t_ptr'(1)) : (r_idx - t_ptr'(1));
                    n_state = S_MOVE_RD;
                end
            end
            S_PUSH: begin
                wr_en   = 1'b1;
                wr_data = r_value;
                if (r_sel == SEL_LOW) begin
                    n_low_top = r_low_top + t_ptr'(1);
                    wr_addr   = n_low_top[IW-1:0];
                end else if (r_sel == SEL_HIGH) begin
                    n_high_top = r_high_top - t_ptr'(1);
                    wr_addr    = n_high_top[IW-1:0];
                end else begin
                    n_mid_top = r_mid_top + t_ptr'(1);
                    wr_addr   = n_mid_top[IW-1:0];
                end
                n_state = S_FINISH;
            end
            S_POP_RD: begin
                // read word lands in r_rd_data
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low_top   <= PTR_NEG_ONE;
            r_high_top  <= PTR_DEPTH;
            r_mid_top   <= PTR_MID_TOP;
            r_mid_bot   <= PTR_MID_BOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low_top   <= n_low_top;
            r_high_top  <= n_high_top;
            r_mid_top   <= n_mid_top;
            r_mid_bot   <= n_mid_bot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_sel   <= n_sel;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_dist  <= n_dist;
        r_ok    <= n_ok;
        if (load_out) begin
            r_o_success <= r_ok;
            r_o_popped  <= (r_ok && r_op != OP_PUSH) ? r_rd_data : t_word'(0);
            r_o_full    <= is_full;
            r_o_low_e   <= r_low_top == PTR_NEG_ONE;
            r_o_high_e  <= r_high_top == PTR_DEPTH;
            r_o_mid_e   <= !mid_nonempty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_success      = r_o_success;
    assign o_popped_value = r_o_popped;
    assign o_all_full     = r_o_full;
    assign o_low_empty    = r_o_low_e;
    assign o_high_empty   = r_o_high_e;
    assign o_middle_empty = r_o_mid_e;

endmodule
`default_nettype wire

### tb/three_stacks_one_array_test.sv
`default_nettype none
module three_stacks_one_array_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsoa_pkg::*;

    localparam logic       OP_POP     = ~OP_PUSH;
    localparam logic [1:0] SEL_MID    = 2'd2;
    localparam logic [1:0] SEL_THREE  = 2'd3;
    localparam int         RANDOM_WORDS = 800;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int         MAX_PRINTED  = 50;

    typedef struct packed {
        logic       op;
        logic [1:0] sel;
        t_word      value;
    } t_stack_req;

    typedef struct packed {
        logic  success;
        t_word popped_value;
        logic  all_full;
        logic  low_empty;
        logic  high_empty;
        logic  middle_empty;
    } t_stack_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_op           = OP_PUSH;
    logic [1:0]  i_stack_select = SEL_LOW;
    t_word       i_value        = '0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_success;
    t_word       o_popped_value;
    logic        o_all_full;
    logic        o_low_empty;
    logic        o_high_empty;
    logic        o_middle_empty;

    t_stack_req    pending_words[$];
    t_stack_result expected_results[$];

    // predicted stack state
    t_word model_store [DEPTH];
    int    low_top  = -1;
    int    high_top = DEPTH;
    int    mid_top  = DEPTH / 2;
    int    mid_bot  = DEPTH / 2 + 1;

    int words_in      = 0;
    int results_seen  = 0;
    int n_errors      = 0;
    int full_refusals = 0;
    int empty_pops    = 0;
    int middle_moves  = 0;
    int idle_cycles   = 0;
    int hold_left     = 0;
    bit held_once     = 1'b0;

    three_stacks_one_array u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_stack_select (i_stack_select),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_success      (o_success),
        .o_popped_value (o_popped_value),
        .o_all_full     (o_all_full),
        .o_low_empty    (o_low_empty),
        .o_high_empty   (o_high_empty),
        .o_middle_empty (o_middle_empty)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit array_full();
        return (low_top + 1 == mid_bot) && (mid_top + 1 == high_top);
    endfunction

    function automatic void shift_middle(int shift_by);
        int    count;
        t_word tmp [DEPTH];
        count = mid_top - mid_bot + 1;
        for (int k = 0; k < count; k++) tmp[k] = model_store[mid_bot + k];
        for (int k = 0; k < count; k++) model_store[mid_bot + shift_by + k] = tmp[k];
        mid_bot += shift_by;
        mid_top += shift_by;
        middle_moves++;
    endfunction

    function automatic t_stack_result stack_step(logic op, logic [1:0] sel, t_word value);
        t_stack_result r;
        r = '0;
        if (op == OP_PUSH) begin
            if (array_full()) begin
                full_refusals++;
            end else begin
                r.success = 1'b1;
                if (sel == SEL_LOW) begin
                    // low stack runs into the middle one: push it up
                    if (low_top + 1 == mid_bot) shift_middle((high_top - mid_top - 1) / 2 + 1);
                    low_top++;
                    model_store[low_top] = value;
                end else begin
                    if (mid_top + 1 == high_top)
                        shift_middle(-((mid_bot - low_top - 1) / 2 + 1));
                    if (sel == SEL_HIGH) begin
                        high_top--;
                        model_store[high_top] = value;
                    end else begin
                        mid_top++;
                        model_store[mid_top] = value;
                    end
                end
            end
        end else begin
            if (sel == SEL_LOW) begin
                if (low_top >= 0) begin
                    r.success      = 1'b1;
                    r.popped_value = model_store[low_top];
                    low_top--;
                end
            end else if (sel == SEL_HIGH) begin
                if (high_top < DEPTH) begin
                    r.success      = 1'b1;
                    r.popped_value = model_store[high_top];
                    high_top++;
                end
            end else begin
                if (mid_top >= mid_bot) begin
                    r.success      = 1'b1;
                    r.popped_value = model_store[mid_top];
                    mid_top--;
                end
            end
            if (!r.success) empty_pops++;
        end
        r.all_full     = array_full();
        r.low_empty    = (low_top == -1);
        r.high_empty   = (high_top == DEPTH);
        r.middle_empty = (mid_top < mid_bot);
        return r;
    endfunction

    task automatic report_error(string msg);
        if (n_errors < MAX_PRINTED) $display("ERROR result %0d: %s", results_seen, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // idle percentages per phase: sender 31/receiver 52, then swapped, then none
    function automatic bit idle_now(bit sender);
        int pct;
        if (words_in < 275) pct = sender ? 31 : 52;
        else if (words_in < 550) pct = sender ? 52 : 31;
        else pct = 0;
        return $urandom_range(99) < pct;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_stack_req w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(stack_step(i_op, i_stack_select, i_value));
                words_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() > 0 && !idle_now(1'b1)) begin
                    w = pending_words.pop_front();
                    i_in_valid     <= 1'b1;
                    i_op           <= w.op;
                    i_stack_select <= w.sel;
                    i_value        <= w.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_error("result word with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("success", 32'(o_success), 32'(want.success));
                    check_field("popped_value", o_popped_value, want.popped_value);
                    check_field("all_full", 32'(o_all_full), 32'(want.all_full));
                    check_field("low_empty", 32'(o_low_empty), 32'(want.low_empty));
                    check_field("high_empty", 32'(o_high_empty), 32'(want.high_empty));
                    check_field("middle_empty", 32'(o_middle_empty),
                                32'(want.middle_empty));
                end
                results_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (results_seen == 150 && !held_once) begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_now(1'b0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("three_stacks_one_array_test: errors");
        $finish;
    end

    initial begin : stimulus
        int         n_made;
        int         burst_len;
        int         push_pct;
        t_stack_req w;

        for (int k = 0; k < DEPTH; k++) model_store[k] = '0;

        // pops on every empty stack, select three included
        pending_words.push_back('{OP_POP, SEL_LOW, 32'h1234_5678});
        pending_words.push_back('{OP_POP, SEL_HIGH, '0});
        pending_words.push_back('{OP_POP, SEL_MID, '1});
        pending_words.push_back('{OP_POP, SEL_THREE, '0});
        // value extremes onto each stack
        pending_words.push_back('{OP_PUSH, SEL_LOW, 32'h7fff_ffff});
        pending_words.push_back('{OP_PUSH, SEL_HIGH, 32'h8000_0000});
        pending_words.push_back('{OP_PUSH, SEL_MID, 32'h0000_0000});
        pending_words.push_back('{OP_PUSH, SEL_THREE, 32'hffff_ffff});
        pending_words.push_back('{OP_PUSH, SEL_LOW, 32'h0000_0001});
        pending_words.push_back('{OP_PUSH, SEL_HIGH, 32'h5555_5555});
        pending_words.push_back('{OP_PUSH, SEL_MID, 32'haaaa_aaaa});
        // unwind them, then pop once more past empty
        pending_words.push_back('{OP_POP, SEL_THREE, 32'hdead_beef});
        pending_words.push_back('{OP_POP, SEL_MID, '0});
        pending_words.push_back('{OP_POP, SEL_MID, '0});
        pending_words.push_back('{OP_POP, SEL_HIGH, '1});
        pending_words.push_back('{OP_POP, SEL_HIGH, '0});
        pending_words.push_back('{OP_POP, SEL_LOW, '0});
        pending_words.push_back('{OP_POP, SEL_LOW, '0});
        pending_words.push_back('{OP_POP, SEL_LOW, '0});
        pending_words.push_back('{OP_POP, SEL_HIGH, '0});

        // random bursts: push-heavy ones fill the store and force middle moves
        n_made = 0;
        while (n_made < RANDOM_WORDS) begin
            burst_len = $urandom_range(20, 90);
            case ($urandom_range(4))
                0: push_pct = 95;
                1: push_pct = 75;
                2: push_pct = 50;
                3: push_pct = 25;
                default: push_pct = 10;
            endcase
            for (int k = 0; k < burst_len; k++) begin
                w.op    = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
                w.sel   = ($urandom_range(9) == 0) ? SEL_THREE : 2'($urandom_range(2));
                w.value = $urandom;
                pending_words.push_back(w);
                n_made++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words in, %0d results checked, %0d middle stack moves",
                 words_in, results_seen, middle_moves);
        $display("%0d pushes refused on a full store, %0d pops on an empty stack",
                 full_refusals, empty_pops);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("three_stacks_one_array_test: clean");
        else
            $display("three_stacks_one_array_test: errors");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/tsoa_pkg.sv
rtl/three_stacks_one_array.sv
tb/three_stacks_one_array_test.sv
